### rtl/core/mss_pkg.sv
package mss_pkg;

	// result kinds
	localparam logic [1:0] KIND_OFF    = 2'd0;
	localparam logic [1:0] KIND_ON     = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;
	localparam logic [1:0] KIND_READ   = 2'd3;

	// action codes
	localparam logic [3:0] ACT_TICK      = 4'd0;
	localparam logic [3:0] ACT_START     = 4'd1;
	localparam logic [3:0] ACT_STOP      = 4'd2;
	localparam logic [3:0] ACT_TOGGLE    = 4'd3;
	localparam logic [3:0] ACT_SET_NV    = 4'd4;
	localparam logic [3:0] ACT_SET_VEL   = 4'd5;
	localparam logic [3:0] ACT_SET_NOTE  = 4'd6;
	localparam logic [3:0] ACT_SET_PAD   = 4'd7;
	localparam logic [3:0] ACT_CLR_TRACK = 4'd8;
	localparam logic [3:0] ACT_CLR_ALL   = 4'd9;
	localparam logic [3:0] ACT_READ      = 4'd10;

	// configuration register indexes
	localparam logic [1:0] REG_MUTE  = 2'd0;
	localparam logic [1:0] REG_LENS  = 2'd1;
	localparam logic [1:0] REG_ROOTS = 2'd2;

	localparam logic [7:0]  TOGGLE_VEL     = 8'd100;
	localparam logic [4:0]  NOTE_LIMIT     = 5'd16;   // room left for the status word
	localparam logic [47:0] LENS_RESET     = 48'hFFFF_FFFF_FFFF;
	localparam logic [63:0] ROOTS_RESET    = 64'h4340_3C27_2E2A_2624;

	function automatic logic [7:0] default_root(input logic [2:0] t);
		case (t)
			3'd0:    default_root = 8'd36;
			3'd1:    default_root = 8'd38;
			3'd2:    default_root = 8'd42;
			3'd3:    default_root = 8'd46;
			3'd4:    default_root = 8'd39;
			3'd5:    default_root = 8'd60;
			3'd6:    default_root = 8'd64;
			default: default_root = 8'd67;
		endcase
	endfunction

endpackage

### rtl/core/multitrack_step_sequencer_unit.sv
// multitrack step sequencer: TRACKS tracks of STEPS steps, driven one action word at a time
// input channel (in_valid/in_ready) takes an action word: tick, start, stop, edits, read
// output channel (out_valid/out_ready) gives result words; last marks the final one of an action
// configuration channel (cfg_valid/cfg_ready, always ready) writes mute, lengths and roots
// tick and start give note-offs, note-ons and one status word; stop gives no note-ons
// read gives one step word; edits give none
// after an action word is taken the sequencer decodes it; a running tick, a start or a
//   stop then releases every track, and a running tick or a start selects each unmuted
//   track, runs SW remainder steps, reads and triggers (a muted track is only selected);
//   the status word ends the action, and a tick while stopped gives only the status word;
//   in_ready stays low until the sequencer is back in idle
// one shared bit-serial remainder unit works out each unmuted track's step index in turn
// after reset the step memory is swept, one entry a cycle, over TRACKS*STEPS entries
//   (rounded up to powers of two, 512 entries here); in_ready stays low during the sweep
// a result word waits in the output register while the receiver stalls, and the
// sequencer holds before loading another word until it is taken; each word keeps its own
// position and playing flag, so the next action word may be taken while the last word still waits
module multitrack_step_sequencer_unit #(
	parameter int TRACKS = 8,
	parameter int STEPS  = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  action,
	input  logic [2:0]  track,
	input  logic [5:0]  step_index,
	input  logic [7:0]  note_value,
	input  logic [7:0]  velocity_value,
	input  logic [7:0]  pad_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [2:0]  out_track,
	output logic [7:0]  out_note,
	output logic [7:0]  out_velocity,
	output logic [7:0]  out_pad,
	output logic [5:0]  current_position,
	output logic        is_playing,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import mss_pkg::*;

	localparam int TW    = (TRACKS > 1) ? $clog2(TRACKS) : 1;
	localparam int SW    = $clog2(STEPS);
	localparam int AW    = TW + SW;
	localparam int DEPTH = 1 << AW;
	localparam int BCW   = $clog2(SW + 1);

	// sequencer states
	localparam logic [3:0] S_INIT = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_DEC  = 4'd2;
	localparam logic [3:0] S_REL  = 4'd3;
	localparam logic [3:0] S_TSEL = 4'd4;
	localparam logic [3:0] S_MOD  = 4'd5;
	localparam logic [3:0] S_RD   = 4'd6;
	localparam logic [3:0] S_TRG  = 4'd7;
	localparam logic [3:0] S_STAT = 4'd8;
	localparam logic [3:0] S_TOGR = 4'd9;
	localparam logic [3:0] S_TOGW = 4'd10;
	localparam logic [3:0] S_RDA  = 4'd11;
	localparam logic [3:0] S_RDO  = 4'd12;
	localparam logic [3:0] S_CLR  = 4'd13;

	logic [3:0]  state_q;

	// configuration registers
	logic [7:0]  mute_q;
	logic [47:0] lens_q;
	logic [63:0] roots_q;

	// captured action word
	logic [3:0]  act_q;
	logic [2:0]  trk_q;
	logic [5:0]  st_q;
	logic [7:0]  note_q;
	logic [7:0]  vel_q;
	logic [7:0]  pad_q;
	logic        ok_q;

	// playback state
	logic [SW-1:0] pos_q;
	logic          run_q;
	logic [7:0]    snd_note_q [TRACKS];
	logic [TRACKS-1:0] snd_flag_q;

	// walk and remainder unit
	logic [TW-1:0]  t_q;
	logic [SW-1:0]  idx_q;
	logic [SW-1:0]  sh_q;
	logic [6:0]     rem_q;
	logic [BCW-1:0] bc_q;
	logic [4:0]     rcnt_q;
	logic [AW-1:0]  clr_q;

	// output register
	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [2:0]  otrk_q;
	logic [7:0]  onote_q;
	logic [7:0]  ovel_q;
	logic [7:0]  opad_q;
	logic        olast_q;
	logic [5:0]  opos_q;
	logic        oplay_q;

	// step memory, split so a clear touches velocity only
	logic [7:0]  mem_note [DEPTH];
	logic [7:0]  mem_vel  [DEPTH];
	logic [7:0]  mem_pad  [DEPTH];
	logic [7:0]  rd_note_q;
	logic [7:0]  rd_vel_q;
	logic [7:0]  rd_pad_q;

	logic [AW-1:0] addr_c;
	logic          we_note_c;
	logic          we_vel_c;
	logic          we_pad_c;
	logic [7:0]    wd_note_c;
	logic [7:0]    wd_vel_c;
	logic [7:0]    wd_pad_c;

	logic        out_free;
	logic        out_load_c;
	logic        t_last;
	logic        t_low;
	logic        t_muted;
	logic [6:0]  lenp_c;
	logic [6:0]  rtmp_c;
	logic [6:0]  rnext_c;
	logic        room_c;
	logic        rel_go;
	logic        trg_go;
	logic [5:0]  lens_a [8];
	logic [7:0]  roots_a [8];

	genvar gi;
	generate
		for (gi = 0; gi < 8; gi++) begin : g_cfg
			assign lens_a[gi]  = lens_q[6*gi +: 6];
			assign roots_a[gi] = roots_q[8*gi +: 8];
		end
	endgenerate

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign out_free  = !out_valid_q || out_ready;
	assign room_c    = (rcnt_q < NOTE_LIMIT);

	assign t_last  = (32'(t_q) == TRACKS - 1);
	assign t_low   = (32'(t_q) < 32'd8);
	assign t_muted = t_low && mute_q[3'(t_q)];

	// one restoring remainder step: shift in the next position bit, subtract the length plus one where it fits
	assign lenp_c  = 7'(lens_a[3'(t_q)]) + 7'd1;
	assign rtmp_c  = {rem_q[5:0], sh_q[SW-1]};
	assign rnext_c = (rtmp_c >= lenp_c) ? (rtmp_c - lenp_c) : rtmp_c;

	assign rel_go = !snd_flag_q[t_q] || !room_c || out_free;
	assign trg_go = (rd_vel_q == 8'd0) || !room_c || out_free;

	// a new word goes into the output register this cycle
	assign out_load_c = ((state_q == S_REL) && rel_go && snd_flag_q[t_q] && room_c)
		|| ((state_q == S_TRG) && trg_go && (rd_vel_q != 8'd0) && room_c)
		|| (((state_q == S_STAT) || (state_q == S_RDO)) && out_free);

	// memory address and write control
	always_comb begin
		addr_c    = {TW'(trk_q), SW'(st_q)};
		we_note_c = 1'b0;
		we_vel_c  = 1'b0;
		we_pad_c  = 1'b0;
		wd_note_c = note_q;
		wd_vel_c  = vel_q;
		wd_pad_c  = pad_q;
		case (state_q)
			S_INIT: begin
				addr_c    = clr_q;
				we_note_c = 1'b1;
				we_vel_c  = 1'b1;
				we_pad_c  = 1'b1;
				wd_note_c = default_root(3'(clr_q[AW-1 -: TW]));
				wd_vel_c  = 8'd0;
				wd_pad_c  = 8'd0;
			end
			S_CLR: begin
				addr_c   = (act_q == ACT_CLR_ALL) ? clr_q : {TW'(trk_q), clr_q[SW-1:0]};
				we_vel_c = 1'b1;
				wd_vel_c = 8'd0;
			end
			S_RD, S_TRG: begin
				addr_c = {t_q, idx_q};
			end
			S_DEC: begin
				if (ok_q) begin
					case (act_q)
						ACT_SET_NV: begin
							we_note_c = 1'b1;
							we_vel_c  = 1'b1;
						end
						ACT_SET_VEL:  we_vel_c  = 1'b1;
						ACT_SET_NOTE: we_note_c = 1'b1;
						ACT_SET_PAD:  we_pad_c  = 1'b1;
						default: ;
					endcase
				end
			end
			S_TOGW: begin
				we_vel_c = 1'b1;
				if (rd_vel_q != 8'd0) begin
					wd_vel_c = 8'd0;
				end else begin
					wd_vel_c  = TOGGLE_VEL;
					we_note_c = 1'b1;
					wd_note_c = roots_a[trk_q];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we_note_c) mem_note[addr_c] <= wd_note_c;
		if (we_vel_c)  mem_vel[addr_c]  <= wd_vel_c;
		if (we_pad_c)  mem_pad[addr_c]  <= wd_pad_c;
		rd_note_q <= mem_note[addr_c];
		rd_vel_q  <= mem_vel[addr_c];
		rd_pad_q  <= mem_pad[addr_c];
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mute_q  <= 8'd0;
			lens_q  <= LENS_RESET;
			roots_q <= ROOTS_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MUTE:  mute_q  <= cfg_data[7:0];
				REG_LENS:  lens_q  <= cfg_data[47:0];
				REG_ROOTS: roots_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			clr_q       <= '0;
			pos_q       <= '0;
			run_q       <= 1'b0;
			snd_flag_q  <= '0;
			for (int i = 0; i < TRACKS; i++) snd_note_q[i] <= 8'd0;
			t_q         <= '0;
			idx_q       <= '0;
			sh_q        <= '0;
			rem_q       <= '0;
			bc_q        <= '0;
			rcnt_q      <= '0;
			act_q       <= ACT_TICK;
			trk_q       <= '0;
			st_q        <= '0;
			note_q      <= '0;
			vel_q       <= '0;
			pad_q       <= '0;
			ok_q        <= 1'b0;
			out_valid_q <= 1'b0;
			kind_q      <= KIND_STATUS;
			otrk_q      <= '0;
			onote_q     <= '0;
			ovel_q      <= '0;
			opad_q      <= '0;
			olast_q     <= 1'b0;
			opos_q      <= '0;
			oplay_q     <= 1'b0;
		end else begin
			if (out_ready && !out_load_c) out_valid_q <= 1'b0;
			// position and playing flag are final once the action is decoded
			if (out_load_c) begin
				opos_q  <= 6'(pos_q);
				oplay_q <= run_q;
			end
			case (state_q)
				S_INIT: begin
					clr_q <= clr_q + AW'(1);
					if (&clr_q) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						act_q   <= action;
						trk_q   <= track;
						st_q    <= step_index;
						note_q  <= note_value;
						vel_q   <= velocity_value;
						pad_q   <= pad_value;
						ok_q    <= (32'(track) < TRACKS) && (32'(step_index) < STEPS);
						rcnt_q  <= '0;
						t_q     <= '0;
						clr_q   <= '0;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					state_q <= S_IDLE;
					case (act_q)
						ACT_TICK: begin
							if (run_q) begin
								pos_q   <= (32'(pos_q) == STEPS - 1) ? '0 : pos_q + SW'(1);
								state_q <= S_REL;
							end else begin
								state_q <= S_STAT;
							end
						end
						ACT_START: begin
							run_q   <= 1'b1;
							pos_q   <= '0;
							state_q <= S_REL;
						end
						ACT_STOP: begin
							run_q   <= 1'b0;
							state_q <= S_REL;
						end
						ACT_TOGGLE: if (ok_q) state_q <= S_TOGR;
						ACT_READ:   state_q <= ok_q ? S_RDA : S_RDO;
						ACT_CLR_TRACK: if (32'(trk_q) < TRACKS) state_q <= S_CLR;
						ACT_CLR_ALL:   state_q <= S_CLR;
						default: ;
					endcase
				end
				S_REL: begin
					if (rel_go) begin
						if (snd_flag_q[t_q] && room_c) begin
							out_valid_q <= 1'b1;
							kind_q      <= KIND_OFF;
							otrk_q      <= 3'(t_q);
							onote_q     <= snd_note_q[t_q];
							ovel_q      <= 8'd0;
							opad_q      <= 8'd0;
							olast_q     <= 1'b0;
							rcnt_q      <= rcnt_q + 5'd1;
						end
						snd_flag_q[t_q] <= 1'b0;
						if (t_last) begin
							t_q     <= '0;
							state_q <= (act_q == ACT_STOP) ? S_STAT : S_TSEL;
						end else begin
							t_q <= t_q + TW'(1);
						end
					end
				end
				S_TSEL: begin
					if (t_muted) begin
						if (t_last) state_q <= S_STAT;
						else        t_q     <= t_q + TW'(1);
					end else if (!t_low) begin
						idx_q   <= pos_q;
						state_q <= S_RD;
					end else begin
						rem_q   <= '0;
						sh_q    <= pos_q;
						bc_q    <= BCW'(SW);
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					rem_q <= rnext_c;
					sh_q  <= sh_q << 1;
					bc_q  <= bc_q - BCW'(1);
					if (bc_q == BCW'(1)) begin
						idx_q   <= SW'(rnext_c);
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_TRG;
				S_TRG: begin
					if (trg_go) begin
						if (rd_vel_q != 8'd0) begin
							snd_note_q[t_q] <= rd_note_q;
							snd_flag_q[t_q] <= 1'b1;
							if (room_c) begin
								out_valid_q <= 1'b1;
								kind_q      <= KIND_ON;
								otrk_q      <= 3'(t_q);
								onote_q     <= rd_note_q;
								ovel_q      <= rd_vel_q;
								opad_q      <= rd_pad_q;
								olast_q     <= 1'b0;
								rcnt_q      <= rcnt_q + 5'd1;
							end
						end
						if (t_last) begin
							state_q <= S_STAT;
						end else begin
							t_q     <= t_q + TW'(1);
							state_q <= S_TSEL;
						end
					end
				end
				S_STAT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						kind_q      <= KIND_STATUS;
						otrk_q      <= '0;
						onote_q     <= '0;
						ovel_q      <= '0;
						opad_q      <= '0;
						olast_q     <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_TOGR: state_q <= S_TOGW;
				S_TOGW: state_q <= S_IDLE;
				S_RDA:  state_q <= S_RDO;
				S_RDO: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						kind_q      <= KIND_READ;
						otrk_q      <= trk_q;
						onote_q     <= ok_q ? rd_note_q : 8'd0;
						ovel_q      <= ok_q ? rd_vel_q : 8'd0;
						opad_q      <= ok_q ? rd_pad_q : 8'd0;
						olast_q     <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if ((act_q == ACT_CLR_ALL) ? (&clr_q) : (&clr_q[SW-1:0]))
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign kind             = kind_q;
	assign out_track        = otrk_q;
	assign out_note         = onote_q;
	assign out_velocity     = ovel_q;
	assign out_pad          = opad_q;
	assign current_position = opos_q;
	assign is_playing       = oplay_q;
	assign last             = olast_q;

endmodule

### rtl/core/mss_check.sv
module mss_check (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  kind,
	input logic [7:0]  out_note,
	input logic [7:0]  out_velocity,
	input logic        last
);
	import mss_pkg::*;

	// a stalled word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	// one word at a time: no second word taken straight after one
	a_in_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken on consecutive cycles");

	// the status word closes its action, note events never do
	a_stat_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_STATUS) |-> last)
		else $error("status word not marked last");

	a_note_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_OFF || kind == KIND_ON) |-> !last)
		else $error("note event marked last");

	a_stat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_STATUS) |-> (out_note == 8'd0) && (out_velocity == 8'd0))
		else $error("status word carries note data");

endmodule

bind multitrack_step_sequencer_unit mss_check u_mss_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.kind         (kind),
	.out_note     (out_note),
	.out_velocity (out_velocity),
	.last         (last)
);
